// ===== hdl/pwbr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwbr_pkg
// Shared types and constants of the pulse-width bus receiver.
// ----------------------------------------------------------------------------
package pwbr_pkg;

    localparam int FRAME_BYTES = 12;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
    localparam logic [15:0] DUR_SAT  = 16'd32767;
    localparam logic [15:0] IDLE_CAP = 16'd1000;

    localparam logic [2:0] CFG_VPW     = 3'd0;
    localparam logic [2:0] CFG_SOF     = 3'd1;
    localparam logic [2:0] CFG_ACTIVE  = 3'd2;
    localparam logic [2:0] CFG_PASSIVE = 3'd3;
    localparam logic [2:0] CFG_BREAK   = 3'd4;
    localparam logic [2:0] CFG_END     = 3'd5;
    localparam logic [2:0] CFG_GAP     = 3'd6;

    typedef enum logic [3:0] {
        DS_SOF_A = 4'd0, DS_SOF_P = 4'd1, DS_ACT0 = 4'd2, DS_ACT1 = 4'd3,
        DS_PAS0 = 4'd4, DS_PAS1 = 4'd5, DS_BRK_A = 4'd6, DS_BRK_P = 4'd7,
        DS_EOD = 4'd8, DS_EOF = 4'd9, DS_IFS = 4'd10, DS_ABORT = 4'd11
    } dstate_t;

    // sequencer states
    typedef enum logic [2:0] {
        SQ_IDLE, SQ_DIFF, SQ_CLASS, SQ_APPLY, SQ_TICK, SQ_EMIT
    } seq_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] stamp;
        logic        line_level;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [3:0] byte_index;
        logic       last_byte;
        logic       frame_aborted;
    } out_item_t;

    // window slot selector for the shared compare unit
    typedef enum logic [3:0] {
        W_SOF0, W_SOF1, W_ACT0, W_ACT1, W_PAS0, W_PAS1,
        W_BRK0, W_BRK1, W_EOD, W_EOF, W_GAP
    } win_t;

    localparam int NWIN = 11;

endpackage

// ===== hdl/pwbr_window_unit.sv =====
// ----------------------------------------------------------------------------
// pwbr_window_unit
// Shared window compare: tests one window per cycle against a duration.
// ----------------------------------------------------------------------------
module pwbr_window_unit (
    input  logic [63:0]          sof_windows,
    input  logic [63:0]          active_bit_windows,
    input  logic [63:0]          passive_bit_windows,
    input  logic [63:0]          break_windows,
    input  logic [63:0]          end_windows,
    input  logic [47:0]          gap_window,
    input  pwbr_pkg::win_t       sel,
    input  logic [15:0]          dur,
    output logic                 hit
);
    logic [31:0] pair;

    // pick the min/max pair
    always_comb
    begin
        unique case (sel)
            pwbr_pkg::W_SOF0: pair = sof_windows[31:0];
            pwbr_pkg::W_SOF1: pair = sof_windows[63:32];
            pwbr_pkg::W_ACT0: pair = active_bit_windows[31:0];
            pwbr_pkg::W_ACT1: pair = active_bit_windows[63:32];
            pwbr_pkg::W_PAS0: pair = passive_bit_windows[31:0];
            pwbr_pkg::W_PAS1: pair = passive_bit_windows[63:32];
            pwbr_pkg::W_BRK0: pair = break_windows[31:0];
            pwbr_pkg::W_BRK1: pair = break_windows[63:32];
            pwbr_pkg::W_EOD:  pair = end_windows[31:0];
            pwbr_pkg::W_EOF:  pair = end_windows[63:32];
            pwbr_pkg::W_GAP:  pair = gap_window[31:0];
            default:          pair = 32'h0000_ffff;
        endcase
    end

    assign hit = (pair[15:0] <= dur) && (dur <= pair[31:16]);
endmodule

// ===== hdl/pulse_width_bus_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_width_bus_receiver_unit
// J1850-style PWM/VPW bus decoder with frame buffer and idle-driven emit.
// ----------------------------------------------------------------------------
// edge request: DIFF, then CLASS testing one window per cycle (one window when
// the level repeats, all eleven otherwise), then APPLY
// tick request: DIFF, then TICK; an emit adds EMIT, which reads bytes in turn and waits on out stalls
// one request at a time; in_stall is high while the sequencer is busy
// one shared window comparator serves all interval classification
// rst_n asynchronously clears control state and config; byte store is not
// cleared
module pulse_width_bus_receiver_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  pwbr_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output pwbr_pkg::out_item_t  out_data,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [63:0]          cfg_wdata
);
    localparam int IW = pwbr_pkg::IDX_W;
    localparam int CW = pwbr_pkg::CNT_W;
    localparam int NWIN_W = pwbr_pkg::NWIN;

    // configuration registers
    logic        vpw_reg;
    logic [63:0] sof_reg, act_reg, pas_reg, brk_reg, end_reg;
    logic [47:0] gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpw_reg <= 1'b0;
            sof_reg <= '0; act_reg <= '0; pas_reg <= '0;
            brk_reg <= '0; end_reg <= '0; gap_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pwbr_pkg::CFG_VPW:     vpw_reg <= cfg_wdata[0];
                pwbr_pkg::CFG_SOF:     sof_reg <= cfg_wdata;
                pwbr_pkg::CFG_ACTIVE:  act_reg <= cfg_wdata;
                pwbr_pkg::CFG_PASSIVE: pas_reg <= cfg_wdata;
                pwbr_pkg::CFG_BREAK:   brk_reg <= cfg_wdata;
                pwbr_pkg::CFG_END:     end_reg <= cfg_wdata;
                pwbr_pkg::CFG_GAP:     gap_reg <= cfg_wdata[47:0];
                default:               ;
            endcase
        end
    end

    // decoder state
    pwbr_pkg::seq_t    seq_reg, seq_next;
    pwbr_pkg::dstate_t ds_reg, ds_next;
    logic              plev_reg, plev_next;
    logic [31:0]       ptime_reg, ptime_next;
    logic [7:0]        shf_reg, shf_next;
    logic [3:0]        bits_reg, bits_next;
    logic [CW-1:0]     nbytes_reg, nbytes_next;
    logic              abort_reg, abort_next;
    logic              mode_reg, lev_reg;
    logic [31:0]       stamp_reg;
    logic [31:0]       el_reg;
    logic [15:0]       dur_reg;
    logic [NWIN_W-1:0] hits_reg, hits_next;
    logic [3:0]        wsel_reg, wsel_next;
    logic [CW-1:0]     ecnt_reg, ecnt_next;
    logic [7:0]        store [pwbr_pkg::FRAME_BYTES];
    logic              st_we;
    logic [7:0]        st_wd;
    logic [7:0]        rd_reg;
    logic              ov_reg, ov_next;
    pwbr_pkg::out_item_t od_reg, od_next;
    logic              rd_pend_reg;
    logic [CW-1:0]     rd_pos_reg;
    logic              emit_go;

    logic hit;
    pwbr_window_unit u_win (
        .sof_windows(sof_reg), .active_bit_windows(act_reg),
        .passive_bit_windows(pas_reg), .break_windows(brk_reg),
        .end_windows(end_reg), .gap_window(gap_reg),
        .sel(pwbr_pkg::win_t'(wsel_reg)), .dur(dur_reg), .hit(hit)
    );

    assign in_stall  = (seq_reg != pwbr_pkg::SQ_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = od_reg;

    // next byte read only when the output slot and read stage are empty
    assign emit_go = !ov_reg && !rd_pend_reg;

    // symbol decode from the collected window hits
    pwbr_pkg::dstate_t dd;
    logic              pb_en, pb_val, endck;
    pwbr_pkg::dstate_t end_tgt;
    always_comb
    begin
        dd = ds_reg; pb_en = 1'b0; pb_val = 1'b0; endck = 1'b0;
        end_tgt = pwbr_pkg::DS_EOF;
        if (!vpw_reg)
        begin
            if (lev_reg)
            begin
                if (hits_reg[pwbr_pkg::W_BRK0]) dd = pwbr_pkg::DS_BRK_P;
                else if (hits_reg[pwbr_pkg::W_SOF0])
                    dd = (ds_reg == pwbr_pkg::DS_SOF_A) ? pwbr_pkg::DS_SOF_P
                                                        : pwbr_pkg::DS_ABORT;
                else if (hits_reg[pwbr_pkg::W_ACT0]) dd = pwbr_pkg::DS_PAS0;
                else if (hits_reg[pwbr_pkg::W_ACT1]) dd = pwbr_pkg::DS_PAS1;
                else dd = pwbr_pkg::DS_ABORT;
            end
            else if (ds_reg == pwbr_pkg::DS_BRK_P && hits_reg[pwbr_pkg::W_BRK1])
                dd = pwbr_pkg::DS_IFS;
            else if (ds_reg == pwbr_pkg::DS_IFS && hits_reg[pwbr_pkg::W_GAP])
                dd = pwbr_pkg::DS_SOF_A;
            else if (ds_reg == pwbr_pkg::DS_SOF_P && hits_reg[pwbr_pkg::W_SOF1])
                dd = pwbr_pkg::DS_ACT0;
            else if (ds_reg == pwbr_pkg::DS_PAS0 && hits_reg[pwbr_pkg::W_PAS0])
                pb_en = 1'b1;
            else if (ds_reg == pwbr_pkg::DS_PAS1 && hits_reg[pwbr_pkg::W_PAS1])
            begin
                pb_en = 1'b1; pb_val = 1'b1;
            end
            else if ((ds_reg == pwbr_pkg::DS_PAS0 || ds_reg == pwbr_pkg::DS_PAS1)
                     && hits_reg[pwbr_pkg::W_EOF])
                endck = 1'b1;
            else dd = pwbr_pkg::DS_ABORT;
        end
        else if (lev_reg)
        begin
            if (hits_reg[pwbr_pkg::W_BRK0]) dd = pwbr_pkg::DS_IFS;
            else if (hits_reg[pwbr_pkg::W_SOF0])
                dd = (ds_reg == pwbr_pkg::DS_SOF_A) ? pwbr_pkg::DS_PAS0
                                                    : pwbr_pkg::DS_ABORT;
            else if (hits_reg[pwbr_pkg::W_ACT0])
            begin
                dd = pwbr_pkg::DS_PAS0; pb_en = (ds_reg != pwbr_pkg::DS_EOD);
            end
            else if (hits_reg[pwbr_pkg::W_ACT1])
            begin
                dd = pwbr_pkg::DS_PAS1; pb_en = (ds_reg != pwbr_pkg::DS_EOD);
                pb_val = 1'b1;
            end
            else dd = pwbr_pkg::DS_ABORT;
        end
        else
        begin
            if (ds_reg == pwbr_pkg::DS_IFS && hits_reg[pwbr_pkg::W_GAP])
                dd = pwbr_pkg::DS_SOF_A;
            else if (hits_reg[pwbr_pkg::W_PAS0])
            begin
                pb_en = 1'b1; dd = pwbr_pkg::DS_ACT0;
            end
            else if (hits_reg[pwbr_pkg::W_PAS1])
            begin
                pb_en = 1'b1; pb_val = 1'b1; dd = pwbr_pkg::DS_ACT1;
            end
            else if (ds_reg == pwbr_pkg::DS_PAS0 || ds_reg == pwbr_pkg::DS_PAS1)
            begin
                if (hits_reg[pwbr_pkg::W_EOF]) endck = 1'b1;
                else if (hits_reg[pwbr_pkg::W_EOD])
                begin
                    endck = 1'b1; end_tgt = pwbr_pkg::DS_EOD;
                end
                else dd = pwbr_pkg::DS_ABORT;
            end
            else dd = pwbr_pkg::DS_ABORT;
        end
        if (endck)
            dd = (bits_reg != 4'd0) ? pwbr_pkg::DS_ABORT : end_tgt;
    end

    // sequencer next state
    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            pwbr_pkg::SQ_IDLE:
                if (in_valid) seq_next = pwbr_pkg::SQ_DIFF;
            pwbr_pkg::SQ_DIFF:
                seq_next = mode_reg ? pwbr_pkg::SQ_TICK : pwbr_pkg::SQ_CLASS;
            pwbr_pkg::SQ_CLASS:
                if (lev_reg == plev_reg) seq_next = pwbr_pkg::SQ_APPLY;
                else if (wsel_reg == 4'(pwbr_pkg::NWIN - 1))
                    seq_next = pwbr_pkg::SQ_APPLY;
            pwbr_pkg::SQ_APPLY: seq_next = pwbr_pkg::SQ_IDLE;
            pwbr_pkg::SQ_TICK:
                if ({16'd0, (el_reg > 32'(pwbr_pkg::IDLE_CAP))
                     ? pwbr_pkg::IDLE_CAP : el_reg[15:0]} < {16'd0, gap_reg[47:32]})
                    seq_next = pwbr_pkg::SQ_IDLE;
                else seq_next = pwbr_pkg::SQ_EMIT;
            pwbr_pkg::SQ_EMIT:
                if (emit_go && ecnt_reg == nbytes_reg)
                    seq_next = pwbr_pkg::SQ_IDLE;
            default: seq_next = pwbr_pkg::SQ_IDLE;
        endcase
    end

    // datapath updates per sequencer step
    always_comb
    begin
        ds_next = ds_reg; plev_next = plev_reg; ptime_next = ptime_reg;
        shf_next = shf_reg; bits_next = bits_reg; nbytes_next = nbytes_reg;
        abort_next = abort_reg; hits_next = hits_reg; wsel_next = wsel_reg;
        ecnt_next = ecnt_reg; ov_next = ov_reg; od_next = od_reg;
        st_we = 1'b0; st_wd = shf_reg;
        if (ov_reg && !out_stall) ov_next = 1'b0;
        unique case (seq_reg)
            pwbr_pkg::SQ_IDLE:
            begin
                wsel_next = 4'd0; hits_next = '0; ecnt_next = '0;
            end
            pwbr_pkg::SQ_DIFF: ;
            pwbr_pkg::SQ_CLASS:
            begin
                hits_next[wsel_reg] = hit;
                wsel_next = wsel_reg + 4'd1;
            end
            pwbr_pkg::SQ_APPLY:
            begin
                if (lev_reg != plev_reg)
                begin
                    ds_next = dd;
                    if (pb_en)
                    begin
                        shf_next = {shf_reg[6:0], pb_val};
                        bits_next = bits_reg + 4'd1;
                    end
                    if (endck) bits_next = 4'd0;
                    if (bits_next >= 4'd8)
                    begin
                        st_wd = shf_next;
                        if (nbytes_reg < CW'(pwbr_pkg::FRAME_BYTES))
                        begin
                            st_we = 1'b1;
                            nbytes_next = nbytes_reg + 1'b1;
                        end
                        bits_next = 4'd0;
                    end
                end
                plev_next = lev_reg; ptime_next = stamp_reg;
                if (ds_next == pwbr_pkg::DS_EOD || ds_next == pwbr_pkg::DS_EOF)
                    ds_next = pwbr_pkg::DS_SOF_A;
                else if (ds_next == pwbr_pkg::DS_ABORT)
                begin
                    ds_next = pwbr_pkg::DS_BRK_A; abort_next = 1'b1;
                end
            end
            pwbr_pkg::SQ_TICK: ;
            pwbr_pkg::SQ_EMIT:
            begin
                // ecnt addresses the store; its read data is registered into rd_reg
                if (emit_go)
                begin
                    if (ecnt_reg == nbytes_reg)
                    begin
                        nbytes_next = '0; abort_next = 1'b0;
                    end
                    else
                        ecnt_next = ecnt_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // registered read of the byte store
    logic [CW-1:0] rd_idx;
    assign rd_idx = ecnt_reg;

    always_ff @(posedge clk)
    begin
        if (st_we) store[nbytes_reg[IW-1:0]] <= st_wd;
        if (rd_idx < CW'(pwbr_pkg::FRAME_BYTES)) rd_reg <= store[rd_idx[IW-1:0]];
        if (seq_reg == pwbr_pkg::SQ_IDLE && in_valid)
        begin
            mode_reg <= in_data.mode; lev_reg <= in_data.line_level;
            stamp_reg <= in_data.stamp;
        end
        if (seq_reg == pwbr_pkg::SQ_DIFF)
        begin
            el_reg  <= stamp_reg - ptime_reg;
            dur_reg <= ((stamp_reg - ptime_reg) > 32'(pwbr_pkg::DUR_SAT))
                       ? pwbr_pkg::DUR_SAT : 16'((stamp_reg - ptime_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg <= pwbr_pkg::SQ_IDLE; ds_reg <= pwbr_pkg::DS_SOF_A;
            plev_reg <= 1'b0; ptime_reg <= '0; shf_reg <= '0; bits_reg <= '0;
            nbytes_reg <= '0; abort_reg <= 1'b0; hits_reg <= '0;
            wsel_reg <= '0; ecnt_reg <= '0; ov_reg <= 1'b0; od_reg <= '0;
            rd_pend_reg <= 1'b0; rd_pos_reg <= '0;
        end
        else
        begin
            seq_reg <= seq_next; ds_reg <= ds_next; plev_reg <= plev_next;
            ptime_reg <= ptime_next; shf_reg <= shf_next; bits_reg <= bits_next;
            nbytes_reg <= nbytes_next; abort_reg <= abort_next;
            hits_reg <= hits_next; wsel_reg <= wsel_next; ecnt_reg <= ecnt_next;
            // byte read issued last cycle becomes an output request now
            rd_pend_reg <= (seq_reg == pwbr_pkg::SQ_EMIT) && emit_go
                           && (ecnt_reg != nbytes_reg);
            rd_pos_reg <= ecnt_reg;
            if (rd_pend_reg)
            begin
                ov_reg <= 1'b1;
                od_reg <= '{frame_byte: rd_reg, byte_index: 4'(rd_pos_reg),
                            last_byte: (rd_pos_reg + 1'b1 == nbytes_reg),
                            frame_aborted: abort_reg};
            end
            else
            begin
                ov_reg <= ov_next; od_reg <= od_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // no new request while a frame is being emitted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == pwbr_pkg::SQ_EMIT) |-> in_stall)
        else $error("accepted during emit");
    // byte count never exceeds the store
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        nbytes_reg <= CW'(pwbr_pkg::FRAME_BYTES))
        else $error("byte count overflow");
    // a stalled output holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("output changed under stall");
`endif
endmodule
